>>> sv/dji_pkg.sv
// Shared definitions for the distance joint impulse pipeline.
// Used by dji_sqrt_cell, dji_div_cell and distance_joint_impulse.
package dji_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int SAT_W         = 66;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REST_LENGTH   = 2'd0,
        REG_MAX_ONLY      = 2'd1,
        REG_SPRING_GAIN   = 2'd2,
        REG_INV_TIME_STEP = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-DATA_W:0] top;
        top = v[SAT_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end
        return v[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

>>> sv/dji_sqrt_cell.sv
// One digit cell of the restoring square root chain.
// Depends on dji_pkg for the stage control group.
module dji_sqrt_cell #(
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dji_pkg::t_ctl         i_ctl,
    input  logic [ROOT_W+1:0]     i_rem,
    input  logic [ROOT_W-1:0]     i_root,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ROOT_W+1:0]     o_rem,
    output logic [ROOT_W-1:0]     o_root,
    output logic [2*ROOT_W-1:0]   o_rad,
    output logic [SIDE_W-1:0]     o_side
);

    logic [ROOT_W+3:0] c_rem2;
    logic [ROOT_W+3:0] c_trial;
    logic              c_ge;
    logic [ROOT_W+3:0] c_diff;

    assign c_rem2  = {i_rem, i_rad[2*ROOT_W-1 -: 2]};
    assign c_trial = {2'b00, i_root, 2'b01};
    assign c_ge    = (c_rem2 >= c_trial);
    assign c_diff  = c_rem2 - c_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ctl.en) begin
            o_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            o_rem  <= c_ge ? c_diff[ROOT_W+1:0] : c_rem2[ROOT_W+1:0];
            o_root <= {i_root[ROOT_W-2:0], c_ge};
            o_rad  <= {i_rad[2*ROOT_W-3:0], 2'b00};
            o_side <= i_side;
        end
    end

endmodule

>>> sv/dji_div_cell.sv
// One quotient-bit cell of the restoring divider chain, lanes share a divisor.
// Depends on dji_pkg for the stage control group.
module dji_div_cell #(
    parameter int D_W    = 33,
    parameter int LANES  = 1,
    parameter int NB_W   = 32,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dji_pkg::t_ctl                i_ctl,
    input  logic [D_W-1:0]               i_div,
    input  logic [LANES-1:0][D_W-1:0]    i_r,
    input  logic [LANES-1:0][NB_W-1:0]   i_nb,
    input  logic [LANES-1:0][Q_W-1:0]    i_q,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_valid,
    output logic [D_W-1:0]               o_div,
    output logic [LANES-1:0][D_W-1:0]    o_r,
    output logic [LANES-1:0][NB_W-1:0]   o_nb,
    output logic [LANES-1:0][Q_W-1:0]    o_q,
    output logic [SIDE_W-1:0]            o_side
);

    logic [LANES-1:0][D_W:0]   c_r2;
    logic [LANES-1:0][D_W:0]   c_sub;
    logic [LANES-1:0]          c_ge;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            c_r2[l]  = {i_r[l], i_nb[l][NB_W-1]};
            c_ge[l]  = (c_r2[l] >= {1'b0, i_div});
            c_sub[l] = c_r2[l] - {1'b0, i_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ctl.en) begin
            o_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            o_div  <= i_div;
            o_side <= i_side;
            for (int l = 0; l < LANES; l++) begin
                o_r[l]  <= c_ge[l] ? c_sub[l][D_W-1:0] : c_r2[l][D_W-1:0];
                o_nb[l] <= {i_nb[l][NB_W-2:0], 1'b0};
                o_q[l]  <= {i_q[l][Q_W-2:0], c_ge[l]};
            end
        end
    end

endmodule

>>> sv/distance_joint_impulse.sv
// Distance joint impulse solver: top level with the full pipeline.
// Depends on dji_pkg, dji_sqrt_cell and dji_div_cell.
//
// One joint solve enters per clock unless the pipeline holds, and its impulse
// passes through 17 arithmetic stages, a 33-cell square root chain, a
// FRAC_BITS+1 cell direction divider, a 32-cell impulse divider and the output
// register (FRAC_BITS is 16 for Q16.16). Every cell is one register stage, so the
// rate stays one item per cycle while not held. The pipeline holds only when a
// finished result waits at the output and the stage behind it is occupied.
module distance_joint_impulse #(
    parameter int FRAC_BITS = dji_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // anchor_a_x, anchor_a_y, anchor_b_x, anchor_b_y, vel_a_x, vel_a_y,
    // vel_b_x, vel_b_y, inv_mass_a, inv_mass_b
    input  logic [319:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // impulse_x, impulse_y
    output logic [63:0]  o_m_tdata,
    // applied, degenerate
    output logic [1:0]   o_m_tuser,
    input  logic         i_cfg_we,
    input  logic [dji_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    localparam int R_W    = 33;
    localparam int RAD_W  = 2 * R_W;
    localparam int MS_W   = 33;
    localparam int DQ_W   = FRAC_BITS + 1;
    localparam int DIR_W  = FRAC_BITS + 2;
    localparam int PV_W   = FRAC_BITS + 35;
    localparam int RS_W   = FRAC_BITS + 36;
    localparam int PE_W   = 65;
    localparam int T1_W   = FRAC_BITS + 33;
    localparam int M_W    = 66;
    localparam int KD_W   = FRAC_BITS + 34;
    localparam int SAT_W  = dji_pkg::SAT_W;
    localparam int IQ_W   = 32;
    localparam logic [FRAC_BITS-1:0] DAMP_V = FRAC_BITS'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [31:0] GAIN_RST = 32'(1 << FRAC_BITS);
    localparam logic [31:0] ITS_RST  = 32'(60 << FRAC_BITS);

    typedef struct packed {
        logic              negx;
        logic              negy;
        logic [31:0]       ax;
        logic [31:0]       ay;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic [MS_W-1:0]   msum;
    } t_sq_side;

    typedef struct packed {
        logic              negx;
        logic              negy;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic [MS_W-1:0]   msum;
        logic signed [31:0] rerr;
        logic              act;
        logic              degen;
    } t_dd_side;

    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic signed [DIR_W-1:0] dirx;
        logic signed [DIR_W-1:0] diry;
        logic              act;
        logic              degen;
    } t_id_side;

    localparam int SQ_SW = $bits(t_sq_side);
    localparam int DD_SW = $bits(t_dd_side);
    localparam int ID_SW = $bits(t_id_side);

    // configuration
    logic [30:0] r_rest;
    logic        r_max_only;
    logic [31:0] r_gain;
    logic [31:0] r_its;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest     <= '0;
            r_max_only <= 1'b0;
            r_gain     <= GAIN_RST;
            r_its      <= ITS_RST;
        end else if (i_cfg_we) begin
            unique case (dji_pkg::t_reg_idx'(i_cfg_idx))
                dji_pkg::REG_REST_LENGTH:   r_rest     <= i_cfg_data[30:0];
                dji_pkg::REG_MAX_ONLY:      r_max_only <= i_cfg_data[0];
                dji_pkg::REG_SPRING_GAIN:   r_gain     <= i_cfg_data;
                dji_pkg::REG_INV_TIME_STEP: r_its      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // flow control
    logic        en;
    logic [16:0] r_v;
    logic        r_out_valid;
    logic        sq_valid;
    logic        dd_valid;
    logic        id_valid;

    assign en         = !r_v[16] || !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    // stage 0: differences
    logic signed [32:0] r0_dx, r0_dy, r0_dvx, r0_dvy;
    logic [MS_W-1:0]    r0_msum;
    // stage 1: magnitudes
    logic               r1_negx, r1_negy;
    logic [31:0]        r1_ax, r1_ay;
    logic signed [32:0] r1_dvx, r1_dvy;
    logic [MS_W-1:0]    r1_msum;
    // stage 2: squares
    logic [63:0]        r2_sx, r2_sy;
    t_sq_side           r2_side;
    // stage 3: radicand
    logic [RAD_W-1:0]   r3_rad;
    t_sq_side           r3_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_dx   <= $signed({i_s_tdata[95], i_s_tdata[95:64]})
                     - $signed({i_s_tdata[31], i_s_tdata[31:0]});
            r0_dy   <= $signed({i_s_tdata[127], i_s_tdata[127:96]})
                     - $signed({i_s_tdata[63], i_s_tdata[63:32]});
            r0_dvx  <= $signed({i_s_tdata[223], i_s_tdata[223:192]})
                     - $signed({i_s_tdata[159], i_s_tdata[159:128]});
            r0_dvy  <= $signed({i_s_tdata[255], i_s_tdata[255:224]})
                     - $signed({i_s_tdata[191], i_s_tdata[191:160]});
            r0_msum <= {1'b0, i_s_tdata[287:256]} + {1'b0, i_s_tdata[319:288]};

            r1_negx <= r0_dx[32];
            r1_negy <= r0_dy[32];
            r1_ax   <= r0_dx[32] ? 32'(-r0_dx) : r0_dx[31:0];
            r1_ay   <= r0_dy[32] ? 32'(-r0_dy) : r0_dy[31:0];
            r1_dvx  <= r0_dvx;
            r1_dvy  <= r0_dvy;
            r1_msum <= r0_msum;

            r2_sx        <= 64'(r1_ax) * 64'(r1_ax);
            r2_sy        <= 64'(r1_ay) * 64'(r1_ay);
            r2_side.negx <= r1_negx;
            r2_side.negy <= r1_negy;
            r2_side.ax   <= r1_ax;
            r2_side.ay   <= r1_ay;
            r2_side.dvx  <= r1_dvx;
            r2_side.dvy  <= r1_dvy;
            r2_side.msum <= r1_msum;

            r3_rad  <= RAD_W'(r2_sx) + RAD_W'(r2_sy);
            r3_side <= r2_side;
        end
    end

    // square root chain
    logic [R_W:0][R_W+1:0]   sq_rem;
    logic [R_W:0][R_W-1:0]   sq_root;
    logic [R_W:0][RAD_W-1:0] sq_rad;
    logic [R_W:0][SQ_SW-1:0] sq_side;
    logic [R_W:0]            sq_v;

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = r3_rad;
    assign sq_side[0] = r3_side;
    assign sq_v[0]    = r_v[3];

    for (genvar g = 0; g < R_W; g++) begin : g_sqrt
        dji_sqrt_cell #(.ROOT_W(R_W), .SIDE_W(SQ_SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   ('{en: en, valid: sq_v[g]}),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_rad   (sq_rad[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_v[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    assign sq_valid = sq_v[R_W];

    // stage 4: gate, degenerate, length error
    t_sq_side           c4_side;
    logic signed [33:0] c4_diff;
    logic [R_W-1:0]     r4_dist;
    t_sq_side           r4_side;
    t_dd_side           r4_dd;

    assign c4_side = t_sq_side'(sq_side[R_W]);
    assign c4_diff = $signed({1'b0, sq_root[R_W]}) - $signed({3'b000, r_rest});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dist        <= sq_root[R_W];
            r4_side        <= c4_side;
            r4_dd.negx     <= c4_side.negx;
            r4_dd.negy     <= c4_side.negy;
            r4_dd.dvx      <= c4_side.dvx;
            r4_dd.dvy      <= c4_side.dvy;
            r4_dd.msum     <= c4_side.msum;
            r4_dd.rerr     <= dji_pkg::sat32(SAT_W'(c4_diff));
            r4_dd.degen    <= (sq_root[R_W] == '0) || (c4_side.msum == '0);
            r4_dd.act      <= !((sq_root[R_W] == '0) || (c4_side.msum == '0))
                           && (!r_max_only || (sq_root[R_W] >= R_W'(r_rest)));
        end
    end

    // direction divider chain, x and y lanes
    logic [DQ_W:0]                     dd_v;
    logic [DQ_W:0][R_W-1:0]            dd_div;
    logic [DQ_W:0][1:0][R_W-1:0]       dd_r;
    logic [DQ_W:0][1:0][DQ_W-1:0]      dd_nb;
    logic [DQ_W:0][1:0][DQ_W-1:0]      dd_q;
    logic [DQ_W:0][DD_SW-1:0]          dd_side;

    assign dd_v[0]     = r_v[4];
    assign dd_div[0]   = r4_dist;
    assign dd_r[0][0]  = R_W'(r4_side.ax >> 1);
    assign dd_r[0][1]  = R_W'(r4_side.ay >> 1);
    assign dd_nb[0][0] = {r4_side.ax[0], {FRAC_BITS{1'b0}}};
    assign dd_nb[0][1] = {r4_side.ay[0], {FRAC_BITS{1'b0}}};
    assign dd_q[0]     = '0;
    assign dd_side[0]  = r4_dd;

    for (genvar g = 0; g < DQ_W; g++) begin : g_ddiv
        dji_div_cell #(
            .D_W(R_W), .LANES(2), .NB_W(DQ_W), .Q_W(DQ_W), .SIDE_W(DD_SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   ('{en: en, valid: dd_v[g]}),
            .i_div   (dd_div[g]),
            .i_r     (dd_r[g]),
            .i_nb    (dd_nb[g]),
            .i_q     (dd_q[g]),
            .i_side  (dd_side[g]),
            .o_valid (dd_v[g+1]),
            .o_div   (dd_div[g+1]),
            .o_r     (dd_r[g+1]),
            .o_nb    (dd_nb[g+1]),
            .o_q     (dd_q[g+1]),
            .o_side  (dd_side[g+1])
        );
    end

    assign dd_valid = dd_v[DQ_W];

    // stages 5 to 10: relative speed, removal term, divider setup
    t_dd_side                c5_side;
    logic signed [DIR_W-1:0] r5_dirx, r5_diry, r6_dirx, r6_diry, r7_dirx, r7_diry;
    logic signed [DIR_W-1:0] r8_dirx, r8_diry, r9_dirx, r9_diry;
    logic signed [32:0]      r5_dvx, r5_dvy;
    logic signed [PE_W-1:0]  r5_perr, r6_perr, r7_perr;
    logic signed [PV_W-1:0]  r6_pvx, r6_pvy;
    logic signed [RS_W-1:0]  r7_rsum;
    logic signed [31:0]      r8_remove;
    logic                    r9_neg;
    logic [31:0]             r9_mag;
    logic [MS_W-1:0]         r5_msum, r6_msum, r7_msum, r8_msum, r9_msum, r10_msum;
    logic [9:5]              r_act, r_degen;
    logic [MS_W-1:0]         r10_r;
    logic [31:0]             r10_nb;
    t_id_side                r10_side;
    logic [MS_W-1:0]         c10_r;

    assign c5_side = t_dd_side'(dd_side[DQ_W]);
    assign c10_r   = MS_W'(r9_mag >> (32 - FRAC_BITS));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_dirx    <= c5_side.negx ? -$signed({1'b0, dd_q[DQ_W][0]})
                                       : $signed({1'b0, dd_q[DQ_W][0]});
            r5_diry    <= c5_side.negy ? -$signed({1'b0, dd_q[DQ_W][1]})
                                       : $signed({1'b0, dd_q[DQ_W][1]});
            r5_dvx     <= c5_side.dvx;
            r5_dvy     <= c5_side.dvy;
            r5_perr    <= PE_W'(c5_side.rerr) * $signed(PE_W'(r_its));
            r5_msum    <= c5_side.msum;
            r_act[5]   <= c5_side.act;
            r_degen[5] <= c5_side.degen;

            r6_pvx  <= PV_W'(r5_dvx) * PV_W'(r5_dirx);
            r6_pvy  <= PV_W'(r5_dvy) * PV_W'(r5_diry);
            r6_perr <= r5_perr;
            r6_dirx <= r5_dirx;
            r6_diry <= r5_diry;
            r6_msum <= r5_msum;

            r7_rsum <= RS_W'(r6_pvx) + RS_W'(r6_pvy);
            r7_perr <= r6_perr;
            r7_dirx <= r6_dirx;
            r7_diry <= r6_diry;
            r7_msum <= r6_msum;

            r8_remove <= dji_pkg::sat32(SAT_W'(r7_rsum >>> FRAC_BITS)
                                      + SAT_W'(r7_perr >>> FRAC_BITS));
            r8_dirx   <= r7_dirx;
            r8_diry   <= r7_diry;
            r8_msum   <= r7_msum;

            r9_neg  <= r8_remove[31];
            r9_mag  <= r8_remove[31] ? 32'd0 - 32'(r8_remove) : 32'(r8_remove);
            r9_dirx <= r8_dirx;
            r9_diry <= r8_diry;
            r9_msum <= r8_msum;

            r10_r         <= c10_r;
            r10_nb        <= {r9_mag[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
            r10_msum      <= r9_msum;
            r10_side.neg  <= r9_neg;
            r10_side.ovf  <= (c10_r >= r9_msum);
            r10_side.dirx <= r9_dirx;
            r10_side.diry <= r9_diry;
            r10_side.act  <= r_act[9];
            r10_side.degen <= r_degen[9];

            for (int s = 6; s <= 9; s++) begin
                r_act[s]   <= r_act[s-1];
                r_degen[s] <= r_degen[s-1];
            end
        end
    end

    // impulse divider chain
    logic [IQ_W:0]                 id_v;
    logic [IQ_W:0][MS_W-1:0]       id_div;
    logic [IQ_W:0][0:0][MS_W-1:0]  id_r;
    logic [IQ_W:0][0:0][31:0]      id_nb;
    logic [IQ_W:0][0:0][IQ_W-1:0]  id_q;
    logic [IQ_W:0][ID_SW-1:0]      id_side;

    assign id_v[0]     = r_v[10];
    assign id_div[0]   = r10_msum;
    assign id_r[0][0]  = r10_r;
    assign id_nb[0][0] = r10_nb;
    assign id_q[0]     = '0;
    assign id_side[0]  = r10_side;

    for (genvar g = 0; g < IQ_W; g++) begin : g_idiv
        dji_div_cell #(
            .D_W(MS_W), .LANES(1), .NB_W(32), .Q_W(IQ_W), .SIDE_W(ID_SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   ('{en: en, valid: id_v[g]}),
            .i_div   (id_div[g]),
            .i_r     (id_r[g]),
            .i_nb    (id_nb[g]),
            .i_q     (id_q[g]),
            .i_side  (id_side[g]),
            .o_valid (id_v[g+1]),
            .o_div   (id_div[g+1]),
            .o_r     (id_r[g+1]),
            .o_nb    (id_nb[g+1]),
            .o_q     (id_q[g+1]),
            .o_side  (id_side[g+1])
        );
    end

    assign id_valid = id_v[IQ_W];

    // stages 11 to 16: impulse, damping, gain, projection
    t_id_side                c11_side;
    logic [IQ_W-1:0]         c11_q;
    logic signed [31:0]      r11_imp;
    logic signed [T1_W-1:0]  r12_t1;
    logic signed [32:0]      c13_t1s;
    logic signed [M_W-1:0]   r13_m;
    logic signed [31:0]      r14_k;
    logic signed [KD_W-1:0]  r15_kx, r15_ky;
    logic signed [DIR_W-1:0] r11_dirx, r11_diry, r12_dirx, r12_diry;
    logic signed [DIR_W-1:0] r13_dirx, r13_diry, r14_dirx, r14_diry;
    logic [15:11]            r_act2, r_degen2;
    logic signed [31:0]      r16_ix, r16_iy;
    logic                    r16_act, r16_degen;

    assign c11_side = t_id_side'(id_side[IQ_W]);
    assign c11_q    = id_q[IQ_W][0];
    assign c13_t1s  = 33'(r12_t1 >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (c11_side.ovf || c11_q[IQ_W-1]) begin
                r11_imp <= c11_side.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r11_imp <= c11_side.neg ? 32'd0 - {1'b0, c11_q[IQ_W-2:0]}
                                        : {1'b0, c11_q[IQ_W-2:0]};
            end
            r11_dirx     <= c11_side.dirx;
            r11_diry     <= c11_side.diry;
            r_act2[11]   <= c11_side.act;
            r_degen2[11] <= c11_side.degen;

            r12_t1   <= T1_W'(r11_imp) * $signed(T1_W'(DAMP_V));
            r12_dirx <= r11_dirx;
            r12_diry <= r11_diry;

            r13_m    <= M_W'(c13_t1s) * $signed(M_W'(r_gain));
            r13_dirx <= r12_dirx;
            r13_diry <= r12_diry;

            r14_k    <= dji_pkg::sat32(SAT_W'(r13_m >>> FRAC_BITS));
            r14_dirx <= r13_dirx;
            r14_diry <= r13_diry;

            r15_kx <= KD_W'(r14_k) * KD_W'(r14_dirx);
            r15_ky <= KD_W'(r14_k) * KD_W'(r14_diry);

            r16_ix    <= r_act2[15] ? dji_pkg::sat32(-SAT_W'(r15_kx >>> FRAC_BITS)) : '0;
            r16_iy    <= r_act2[15] ? dji_pkg::sat32(-SAT_W'(r15_ky >>> FRAC_BITS)) : '0;
            r16_act   <= r_act2[15];
            r16_degen <= r_degen2[15];

            for (int s = 12; s <= 15; s++) begin
                r_act2[s]   <= r_act2[s-1];
                r_degen2[s] <= r_degen2[s-1];
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v[0] <= i_s_tvalid;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= sq_valid;
            r_v[5] <= dd_valid;
            for (int s = 6; s <= 10; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_v[11] <= id_valid;
            for (int s = 12; s <= 16; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= r_v[16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            o_m_tdata <= {r16_iy, r16_ix};
            o_m_tuser <= {r16_degen, r16_act};
        end
    end

    assign o_m_tvalid = r_out_valid;

`ifndef ASSERT_OFF
    a_degen_not_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> !o_m_tuser[0])
        else $error("degenerate result marked applied");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("impulse not zero on an idle result");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready && r_v[16])
        else $error("input held without a blocked output");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v))
        else $error("pipeline moved while stalled");
`endif

endmodule
